### rtl/cfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types and constants of the code flash controller.
// ----------------------------------------------------------------------------
package cfc_pkg;

  typedef enum logic [3:0] {
    CmdWrData  = 4'd0,
    CmdWrAddr  = 4'd1,
    CmdWrProt  = 4'd2,
    CmdWrCmd   = 4'd3,
    CmdRdStat  = 4'd4,
    CmdRdData  = 4'd5,
    CmdRdAddr  = 4'd6,
    CmdRdCmd   = 4'd7,
    CmdRdProt  = 4'd8,
    CmdRdWord  = 4'd9,
    CmdRdByte  = 4'd10
  } cfc_cmd_e;

  localparam logic CfgIdxErase = 1'b0;
  localparam logic CfgIdxProg  = 1'b1;

  localparam logic [2:0] StCmdErr = 3'b001;
  localparam logic [2:0] StAddrOk = 3'b010;
  localparam logic [2:0] StAlways = 3'b100;

  localparam int unsigned ProtKeyBit = 7;
  localparam int unsigned ProtWeBit  = 3;

  localparam logic [7:0] EraseOpRst = 8'hA6;
  localparam logic [7:0] ProgOpRst  = 8'h9A;

  localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [31:0] ByteOnes = 32'h0000_00FF;

endpackage

### rtl/code_flash_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_flash_controller_unit
// Code flash controller: register file plus flash word array with one read
// port and one write port. Register access: strobe in the cycle after start.
// Flash byte read: one array read; flash word read: two array reads through
// the one read port. Program: strobe in the cycle after start, busy for a
// read-modify-write. Erase: strobe in the cycle after start, busy while the
// sector base is found in three steps, then one word per cycle through the
// array. After reset busy stays high while the array is filled with ones.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module code_flash_controller_unit
  import cfc_pkg::*;
#(
  parameter int unsigned FLASH_BYTES  = 65536,
  parameter int unsigned SECTOR_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  cmd_i,
  input  logic [31:0] addr_i,
  input  logic [31:0] wdata_i,
  output logic        done_o,
  output logic [31:0] rdata_o,
  output logic [2:0]  status_o
);

  localparam int unsigned WordCount = (FLASH_BYTES + 3) / 4;
  localparam int unsigned IW = $clog2(WordCount);
  localparam int unsigned PW = IW + 1;
  localparam int unsigned BW = $clog2(FLASH_BYTES + 1);
  localparam int unsigned EW = BW + 1;
  localparam int unsigned RW = BW + 1;
  localparam int unsigned Recip = (2 ** BW) / SECTOR_BYTES;
  localparam bit SbFits = SECTOR_BYTES <= FLASH_BYTES;

  localparam logic [31:0]   FlashB32  = 32'(FLASH_BYTES);
  localparam logic [31:0]   WordLim32 = 32'(FLASH_BYTES - 4);
  localparam logic [BW-1:0] ProgLimB  = BW'(FLASH_BYTES - 4);
  localparam logic [RW-1:0] RecipR    = RW'(Recip);
  localparam logic [RW-1:0] SectorR   = RW'(SECTOR_BYTES);
  localparam logic [BW-1:0] SectorB   = BW'(SECTOR_BYTES);
  localparam logic [EW-1:0] SectorE   = EW'(SECTOR_BYTES);
  localparam logic [EW-1:0] EraseLimE = EW'(FLASH_BYTES - SECTOR_BYTES);
  localparam logic [IW-1:0] LastIdx   = IW'(WordCount - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_RW0   = 4'd2;
  localparam logic [3:0] S_RW1   = 4'd3;
  localparam logic [3:0] S_RB    = 4'd4;
  localparam logic [3:0] S_PROG  = 4'd5;
  localparam logic [3:0] S_DIV0  = 4'd6;
  localparam logic [3:0] S_DIV1  = 4'd7;
  localparam logic [3:0] S_DIV2  = 4'd8;
  localparam logic [3:0] S_ERASE = 4'd9;

  logic [31:0] mem_q [WordCount];
  logic [31:0] mem_rdata_q;
  logic        mem_we, mem_re;
  logic [IW-1:0] mem_widx, mem_ridx;
  logic [31:0] mem_wdata;

  logic [3:0]  state_q, state_d;
  logic [31:0] data_q, data_d, addr_q, addr_d;
  logic [7:0]  cmdreg_q, cmdreg_d;
  logic [6:0]  prot_q, prot_d;
  logic        wen_q, wen_d;
  logic [2:0]  status_q, status_d;
  logic [7:0]  erase_op_q, prog_op_q;
  logic        done_q, done_d;
  logic [31:0] rdata_q, rdata_d;
  logic [PW-1:0] ptr_q, ptr_d;
  logic        pend_q, pend_d;

  logic [IW-1:0]    pidx_q, pidx_d, last_q, last_d;
  logic [1:0]       radr_q, radr_d;
  logic [31:0]      w0_q, w0_d;
  logic [BW-1:0]    ea_q, ea_d, qb_q, qb_d;
  logic [BW+RW-1:0] prod_q, prod_d;
  logic [EW-1:0]    base_q, base_d, end_q, end_d;

  logic [2*RW-1:0] qb_full;
  logic [BW-1:0]   rem;
  logic [EW-1:0]   base_c, end_c;
  logic [7:0]      op;
  logic [31:0]     emask;
  logic [EW-1:0]   bya;
  logic [63:0]     pair;
  logic            erd;

  assign busy     = state_q != S_IDLE;
  assign done_o   = done_q;
  assign rdata_o  = rdata_q;
  assign status_o = status_q;

  assign op      = wdata_i[7:0];
  assign qb_full = prod_q[BW+RW-1:BW] * SectorR;
  assign rem     = ea_q - qb_q;
  assign base_c  = (rem >= SectorB) ? (EW'(qb_q) + SectorE) : EW'(qb_q);
  assign end_c   = base_c + SectorE - EW'(1);
  assign pair    = {mem_rdata_q, w0_q};
  assign erd     = ptr_q <= {1'b0, last_q};

  always_comb begin
    emask = '0;
    bya   = '0;
    for (int j = 0; j < 4; j++) begin
      bya = EW'({pidx_q, 2'(j)});
      if (bya >= base_q && bya <= end_q) begin
        emask[8*j +: 8] = 8'hFF;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    data_d   = data_q;
    addr_d   = addr_q;
    cmdreg_d = cmdreg_q;
    prot_d   = prot_q;
    wen_d    = wen_q;
    status_d = status_q;
    done_d   = 1'b0;
    rdata_d  = rdata_q;
    ptr_d    = ptr_q;
    pend_d   = pend_q;
    pidx_d   = pidx_q;
    last_d   = last_q;
    radr_d   = radr_q;
    w0_d     = w0_q;
    ea_d     = ea_q;
    qb_d     = qb_q;
    prod_d   = prod_q;
    base_d   = base_q;
    end_d    = end_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_widx  = pidx_q;
    mem_ridx  = pidx_q;
    mem_wdata = AllOnes;

    unique case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_widx = ptr_q[IW-1:0];
        ptr_d    = ptr_q + PW'(1);
        if (ptr_q[IW-1:0] == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          done_d  = 1'b1;
          rdata_d = '0;
          unique case (cmd_i)
            CmdWrData: data_d = wdata_i;
            CmdWrAddr: addr_d = wdata_i;
            CmdWrProt: begin
              prot_d = wdata_i[6:0];
              wen_d  = wdata_i[ProtKeyBit] && wdata_i[ProtWeBit];
            end
            CmdWrCmd: begin
              cmdreg_d = op;
              if (!wen_q || (op != erase_op_q && op != prog_op_q)) begin
                status_d = StAlways | StCmdErr;
              end else if (addr_q >= FlashB32) begin
                status_d = StAlways;
              end else begin
                status_d = StAlways | StAddrOk;
                if (op == erase_op_q) begin
                  if (SbFits) begin
                    ea_d    = addr_q[BW-1:0];
                    state_d = S_DIV0;
                  end
                end else if ({addr_q[BW-1:2], 2'b00} <= ProgLimB) begin
                  mem_re   = 1'b1;
                  mem_ridx = addr_q[IW+1:2];
                  pidx_d   = addr_q[IW+1:2];
                  state_d  = S_PROG;
                end
              end
            end
            CmdRdStat: rdata_d = {29'd0, status_q};
            CmdRdData: rdata_d = data_q;
            CmdRdAddr: rdata_d = addr_q;
            CmdRdCmd:  rdata_d = {24'd0, cmdreg_q};
            CmdRdProt: rdata_d = {25'd0, prot_q};
            CmdRdWord: begin
              if (addr_i <= WordLim32) begin
                done_d   = 1'b0;
                mem_re   = 1'b1;
                mem_ridx = addr_i[IW+1:2];
                radr_d   = addr_i[1:0];
                pidx_d   = (addr_i[1:0] != 2'b00) ? addr_i[IW+1:2] + IW'(1)
                                                 : addr_i[IW+1:2];
                state_d  = S_RW0;
              end else begin
                rdata_d = AllOnes;
              end
            end
            CmdRdByte: begin
              if (addr_i < FlashB32) begin
                done_d   = 1'b0;
                mem_re   = 1'b1;
                mem_ridx = addr_i[IW+1:2];
                radr_d   = addr_i[1:0];
                state_d  = S_RB;
              end else begin
                rdata_d = ByteOnes;
              end
            end
            default: rdata_d = '0;
          endcase
        end
      end
      S_RW0: begin
        w0_d     = mem_rdata_q;
        mem_re   = 1'b1;
        mem_ridx = pidx_q;
        state_d  = S_RW1;
      end
      S_RW1: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        case (radr_q)
          2'd0:    rdata_d = pair[31:0];
          2'd1:    rdata_d = pair[39:8];
          2'd2:    rdata_d = pair[47:16];
          default: rdata_d = pair[55:24];
        endcase
      end
      S_RB: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        case (radr_q)
          2'd0:    rdata_d = {24'd0, mem_rdata_q[7:0]};
          2'd1:    rdata_d = {24'd0, mem_rdata_q[15:8]};
          2'd2:    rdata_d = {24'd0, mem_rdata_q[23:16]};
          default: rdata_d = {24'd0, mem_rdata_q[31:24]};
        endcase
      end
      S_PROG: begin
        mem_we    = 1'b1;
        mem_widx  = pidx_q;
        mem_wdata = mem_rdata_q & data_q;
        state_d   = S_IDLE;
      end
      S_DIV0: begin
        prod_d  = ea_q * RecipR;
        state_d = S_DIV1;
      end
      S_DIV1: begin
        qb_d    = qb_full[BW-1:0];
        state_d = S_DIV2;
      end
      S_DIV2: begin
        base_d = base_c;
        end_d  = end_c;
        ptr_d  = PW'(base_c >> 2);
        last_d = IW'(end_c >> 2);
        pend_d = 1'b0;
        state_d = (base_c <= EraseLimE) ? S_ERASE : S_IDLE;
      end
      S_ERASE: begin
        pend_d = erd;
        if (erd) begin
          mem_re   = 1'b1;
          mem_ridx = ptr_q[IW-1:0];
          pidx_d   = ptr_q[IW-1:0];
          ptr_d    = ptr_q + PW'(1);
        end
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_widx  = pidx_q;
          mem_wdata = mem_rdata_q | emask;
        end
        if (!erd && !pend_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_widx] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_ridx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      data_q     <= '0;
      addr_q     <= '0;
      cmdreg_q   <= '0;
      prot_q     <= '0;
      wen_q      <= 1'b0;
      status_q   <= StAlways;
      erase_op_q <= EraseOpRst;
      prog_op_q  <= ProgOpRst;
      done_q     <= 1'b0;
      ptr_q      <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      data_q   <= data_d;
      addr_q   <= addr_d;
      cmdreg_q <= cmdreg_d;
      prot_q   <= prot_d;
      wen_q    <= wen_d;
      status_q <= status_d;
      done_q   <= done_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgIdxErase) begin
          erase_op_q <= cfg_wdata_i;
        end
        if (cfg_idx_i == CfgIdxProg) begin
          prog_op_q <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rdata_d;
    pidx_q  <= pidx_d;
    last_q  <= last_d;
    radr_q  <= radr_d;
    w0_q    <= w0_d;
    ea_q    <= ea_d;
    qb_q    <= qb_d;
    prod_q  <= prod_d;
    base_q  <= base_d;
    end_q   <= end_d;
  end

  // read and write of the same word never collide in one cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_widx != mem_ridx))
    else $error("flash array read and write hit the same word");

  a_reg_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i != CmdRdWord && cmd_i != CmdRdByte) |=> done_o)
    else $error("register access gave no result beat");

  a_word_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RW0) |=> ##1 done_o)
    else $error("word read result missing");

  a_status_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o[2])
    else $error("status always-set bit lost");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR || state_q == S_ERASE) |-> (busy && !done_o))
    else $error("result beat during array walk");

endmodule
